[rtl/emb_pkg.sv]
// shared types, register indexes and the per-channel emboss arithmetic
package emb_pkg;

    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;
    localparam int COORD_W = 11;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_DATA_W = 48;
    localparam int SUM_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_SIZE     = 12'd3;
    localparam logic [CFG_W-1:0] MAX_HEIGHT   = 12'd2048;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PIXEL_W-1:0] pixel_t;

    // kernel [-2,-1,0; -1,1,1; 0,1,2], saturated to 0..255
    function automatic chan_t emboss_chan(
        input chan_t tl, input chan_t tm, input chan_t ml, input chan_t cc,
        input chan_t mr, input chan_t bm, input chan_t br);
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        logic signed [SUM_W-1:0] s;
        chan_t res;
        pos = $signed({4'b0, cc}) + $signed({4'b0, mr}) + $signed({4'b0, bm})
            + $signed({3'b0, br, 1'b0});
        neg = $signed({3'b0, tl, 1'b0}) + $signed({4'b0, tm})
            + $signed({4'b0, ml});
        s = pos - neg;
        if (s < 0)
            res = '0;
        else if (s > $signed(12'd255))
            res = 8'hFF;
        else
            res = s[CHAN_W-1:0];
        return res;
    endfunction

endpackage

[rtl/rgb_emboss_3x3_filter.sv]
// the line store read and the pixel are registered when the pixel is accepted, and its
// kernel result when it leaves s1, which waits while the output holds an untaken result
// throughput: one pixel per cycle unless s1 waits, set by one read port per line store
// reset: counters and window cleared, width 640, height 480; line stores keep
// their contents and are not cleared, so the block accepts pixels right away
module rgb_emboss_3x3_filter #(
    parameter int MAX_LINE_PIXELS = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [emb_pkg::PIXEL_W-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16], out_column [34:24],
    // out_row [45:35], zeros [47:46]
    output logic [emb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // frame_done
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [emb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [emb_pkg::CFG_W-1:0]        cfg_data
);
    import emb_pkg::*;

    localparam int CW = $clog2(MAX_LINE_PIXELS);
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_LINE_PIXELS);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic [CW-1:0]      col_reg;
    logic [COORD_W-1:0] row_reg;

    pixel_t upper_mem [MAX_LINE_PIXELS];
    pixel_t middle_mem [MAX_LINE_PIXELS];
    pixel_t top_rd_reg;
    pixel_t mid_rd_reg;

    // pixel waiting for its line store data
    logic               s1_valid_reg;
    pixel_t             s1_px_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [COORD_W-1:0] s1_ocol_reg;
    logic [COORD_W-1:0] s1_orow_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;

    pixel_t win_reg [6];

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic          in_acc;
    logic          s1_adv;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] h_eff;
    logic [WW-1:0] c_ext;
    logic [WW-1:0] r_ext;
    logic          emit_now;
    logic          last_now;
    logic          line_end;
    logic [CW-1:0]      col_next;
    logic [COORD_W-1:0] row_next;
    pixel_t        result;

    always_comb
    begin
        if (WW'(width_reg) < WW'(MIN_SIZE))
            w_eff = WW'(MIN_SIZE);
        else if (WW'(width_reg) > MAX_W)
            w_eff = MAX_W;
        else
            w_eff = WW'(width_reg);
        if (height_reg < MIN_SIZE)
            h_eff = WW'(MIN_SIZE);
        else if (height_reg > MAX_HEIGHT)
            h_eff = WW'(MAX_HEIGHT);
        else
            h_eff = WW'(height_reg);
    end

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign c_ext    = WW'(col_reg);
    assign r_ext    = WW'(row_reg);
    assign emit_now = (c_ext >= WW'(2)) && (r_ext >= WW'(2)) && (c_ext < w_eff)
                      && (r_ext < h_eff);
    assign last_now = (c_ext == w_eff - WW'(1)) && (r_ext == h_eff - WW'(1));
    assign line_end = (c_ext + WW'(1)) >= w_eff;

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (line_end)
        begin
            col_next = '0;
            if ((r_ext + WW'(1)) >= h_eff)
                row_next = '0;
            else
                row_next = row_reg + COORD_W'(1);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            result[k*CHAN_W +: CHAN_W] = emboss_chan(
                win_reg[0][k*CHAN_W +: CHAN_W], win_reg[3][k*CHAN_W +: CHAN_W],
                win_reg[1][k*CHAN_W +: CHAN_W], win_reg[4][k*CHAN_W +: CHAN_W],
                mid_rd_reg[k*CHAN_W +: CHAN_W], win_reg[5][k*CHAN_W +: CHAN_W],
                s1_px_reg[k*CHAN_W +: CHAN_W]);
        end
    end

    // read both lines at the pixel's column; the new pixel goes into the middle line
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            top_rd_reg <= upper_mem[col_reg];
            mid_rd_reg <= middle_mem[col_reg];
            middle_mem[col_reg] <= s_axis_tdata;
        end
    end

    // the middle line moves up when its pixel leaves s1, once its data is back;
    // the next read is always at another column, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            upper_mem[s1_col_reg] <= mid_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_px_reg   <= s_axis_tdata;
            s1_col_reg  <= col_reg;
            s1_ocol_reg <= COORD_W'(col_reg - CW'(1));
            s1_orow_reg <= row_reg - COORD_W'(1);
            s1_emit_reg <= emit_now;
            s1_last_reg <= last_now;
        end
        if (s1_adv)
        begin
            out_data_reg <= {2'b00, s1_orow_reg, s1_ocol_reg, result};
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                out_valid_reg <= s1_emit_reg;
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_rd_reg;
                win_reg[4] <= mid_rd_reg;
                win_reg[5] <= s1_px_reg;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_emit_reg |=> m_axis_tvalid)
        else $error("emitted pixel did not reach the output register");

    a_stall_holds_rd: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> $stable(mid_rd_reg) && $stable(top_rd_reg))
        else $error("line store data changed while its pixel was stalled");

    a_ready_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> s1_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a full pipeline");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < MAX_W)
        else $error("column counter beyond line store depth");

endmodule

[bench/rgb_emboss_3x3_filter_tb.sv]
// self-checking testbench for the rgb emboss 3x3 filter with a built-in pixel predictor
`timescale 1ns / 1ps

module rgb_emboss_3x3_filter_tb;

    import emb_pkg::*;

    localparam int LINE_DEPTH     = 2048;
    localparam int LINE_IDX_W     = $clog2(LINE_DEPTH);
    localparam int RANDOM_PIXELS  = 410;
    localparam int SETTLE_CYCLES  = 6;
    localparam int STALL_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;

    // indexes that select no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam pixel_t WHITE = {PIXEL_W{1'b1}};
    localparam pixel_t BLACK = {PIXEL_W{1'b0}};

    typedef struct packed {
        chan_t               red;
        chan_t               green;
        chan_t               blue;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic                done;
    } embossed_pixel_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [PIXEL_W-1:0]      s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    // predictor state
    logic [CFG_W-1:0]  width_reg = WIDTH_RESET;
    logic [CFG_W-1:0]  height_reg = HEIGHT_RESET;
    pixel_t            line_above [LINE_DEPTH];
    pixel_t            line_middle [LINE_DEPTH];
    pixel_t            win [6] = '{default: '0};
    int unsigned       col_count = 0;
    int unsigned       row_count = 0;

    pixel_t            pending_pixels [$];
    embossed_pixel_t   embossed_due [$];

    int pixels_queued = 0;
    int pixels_accepted = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int reg_writes = 0;
    int send_gap = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit calm_in = 1'b0;
    bit calm_out = 1'b0;

    int kernel_taps [9] = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};

    rgb_emboss_3x3_filter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned size_limit(input logic [CFG_W-1:0] v, input int unsigned hi);
        int unsigned val;
        val = 32'(v);
        if (val < 32'(MIN_SIZE))
            return 32'(MIN_SIZE);
        if (val > hi)
            return hi;
        return val;
    endfunction

    function automatic chan_t emboss_level(input pixel_t tl, tm, ml, cc, mr, bm, br,
                                           input int k);
        int acc;
        acc = int'(cc[CHAN_W*k +: CHAN_W]) + int'(mr[CHAN_W*k +: CHAN_W])
            + int'(bm[CHAN_W*k +: CHAN_W]) + 2 * int'(br[CHAN_W*k +: CHAN_W])
            - 2 * int'(tl[CHAN_W*k +: CHAN_W]) - int'(tm[CHAN_W*k +: CHAN_W])
            - int'(ml[CHAN_W*k +: CHAN_W]);
        if (acc < 0)
            return '0;
        if (acc > 255)
            return 8'hFF;
        return chan_t'(acc);
    endfunction

    task automatic emboss_step(input pixel_t px);
        int unsigned w;
        int unsigned h;
        pixel_t above;
        pixel_t middle;
        embossed_pixel_t want;
        logic [LINE_IDX_W-1:0] idx;
        w = size_limit(width_reg, LINE_DEPTH);
        h = size_limit(height_reg, 32'(MAX_HEIGHT));
        above = '0;
        middle = '0;
        if (col_count < LINE_DEPTH)
        begin
            idx = LINE_IDX_W'(col_count);
            above = line_above[idx];
            middle = line_middle[idx];
            line_above[idx] = middle;
            line_middle[idx] = px;
        end
        // center of the window is one column left and one line up
        if (col_count >= 2 && row_count >= 2 && col_count < w && row_count < h)
        begin
            want.red    = emboss_level(win[0], win[3], win[1], win[4], middle, win[5], px, 0);
            want.green  = emboss_level(win[0], win[3], win[1], win[4], middle, win[5], px, 1);
            want.blue   = emboss_level(win[0], win[3], win[1], win[4], middle, win[5], px, 2);
            want.column = COORD_W'(col_count - 1);
            want.row    = COORD_W'(row_count - 1);
            want.done   = (col_count == w - 1 && row_count == h - 1);
            embossed_due.push_back(want);
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = above;
        win[4] = middle;
        win[5] = px;
        if (col_count + 1 >= w)
        begin
            col_count = 0;
            row_count = (row_count + 1 >= h) ? 0 : row_count + 1;
        end
        else
            col_count++;
    endtask

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                emboss_step(s_axis_tdata);
                pixels_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_pixels.pop_front();
                    send_gap <= pick_gap(calm_in);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_result(input logic [OUT_DATA_W-1:0] data, input logic last);
        embossed_pixel_t got;
        embossed_pixel_t want;
        got.red    = data[0 +: CHAN_W];
        got.green  = data[CHAN_W +: CHAN_W];
        got.blue   = data[2*CHAN_W +: CHAN_W];
        got.column = data[PIXEL_W +: COORD_W];
        got.row    = data[PIXEL_W+COORD_W +: COORD_W];
        got.done   = last;
        results_checked++;
        if (embossed_due.size() == 0)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: unexpected item rgb %h %h %h at (%0d,%0d) last %0b",
                         $realtime, got.red, got.green, got.blue, got.column, got.row,
                         got.done);
            mismatch_count++;
        end
        else
        begin
            want = embossed_due.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
                || got.column !== want.column || got.row !== want.row
                || got.done !== want.done)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: expected %h %h %h (%0d,%0d) %0b, got %h %h %h (%0d,%0d) %0b",
                             $realtime, want.red, want.green, want.blue, want.column,
                             want.row, want.done, got.red, got.green, got.blue,
                             got.column, got.row, got.done);
                mismatch_count++;
            end
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tlast);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold_left <= pick_gap(calm_out);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 9))
            0: return WHITE;
            1: return BLACK;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic queue_pixel(input pixel_t px);
        pending_pixels.push_back(px);
        pixels_queued++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_pixel(random_pixel());
    endtask

    // pixels left until the counters wrap to the top-left corner
    function automatic int pixels_to_frame_end();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int n;
        w = size_limit(width_reg, LINE_DEPTH);
        h = size_limit(height_reg, 32'(MAX_HEIGHT));
        c = col_count;
        r = row_count;
        n = 0;
        do
        begin
            n++;
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                c++;
        end
        while (c != 0 || r != 0);
        return n;
    endfunction

    task automatic wait_drained();
        while (pixels_accepted != pixels_queued || embossed_due.size() != 0)
            @(posedge clk);
        // pixels that emit nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input bit spare);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_W-1:0] val [3];
        int count;
        idx[0] = REG_IMAGE_WIDTH;
        val[0] = w;
        idx[1] = REG_IMAGE_HEIGHT;
        val[1] = h;
        idx[2] = ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
        val[2] = CFG_W'($urandom);
        count = spare ? 3 : 2;
        cfg_valid <= 1'b1;
        for (int i = 0; i < count; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            reg_writes++;
            if (idx[i] == REG_IMAGE_WIDTH)
                width_reg = val[i];
            else if (idx[i] == REG_IMAGE_HEIGHT)
                height_reg = val[i];
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int n;
        int roll;
        int random_pixels;
        int remaining;
        logic [CFG_W-1:0] new_w;
        logic [CFG_W-1:0] new_h;
        pixel_t px;
        random_pixels = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few pixels at the reset size, then shrink in mid-line
        queue_random(10);
        wait_drained();
        program_size(12'd3, 12'd3, 1'b0);
        queue_random(pixels_to_frame_end());
        wait_drained();

        // 3x3 frames: saturation to zero, saturation to full, exact value, frame restart
        for (int f = 0; f < 3; f++)
            for (int p = 0; p < 9; p++)
            begin
                if (f == 0)
                    px = (kernel_taps[p] <= 0) ? WHITE : BLACK;
                else if (f == 1)
                    px = (kernel_taps[p] > 0) ? WHITE : BLACK;
                else
                    px = (kernel_taps[p] == 0) ? random_pixel() : 24'h804020;
                queue_pixel(px);
            end
        wait_drained();

        // oversized width and height clamp, then shrink back in mid-line
        program_size(12'd4095, 12'd4095, 1'b1);
        queue_random(40);
        wait_drained();
        program_size(12'd3, 12'd3, 1'b0);
        queue_random(pixels_to_frame_end());
        wait_drained();

        while (random_pixels < RANDOM_PIXELS)
        begin
            calm_in = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            remaining = RANDOM_PIXELS - random_pixels;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                new_w = CFG_W'($urandom_range(0, 2));
            else if (roll == 1)
                new_w = CFG_W'($urandom_range(25, 64));
            else
                new_w = CFG_W'($urandom_range(3, 24));
            roll = $urandom_range(0, 9);
            if (roll == 0)
                new_h = CFG_W'($urandom_range(0, 2));
            else if (roll == 1)
                new_h = CFG_W'($urandom_range(13, 30));
            else
                new_h = CFG_W'($urandom_range(3, 12));
            if ($urandom_range(0, 4) != 0)
            begin
                // a wider line may only start on a fresh frame, so no unwritten
                // line store entry is ever used
                if (size_limit(new_w, LINE_DEPTH) > size_limit(width_reg, LINE_DEPTH)
                    && (col_count != 0 || row_count != 0))
                begin
                    n = pixels_to_frame_end();
                    if (n <= remaining)
                    begin
                        queue_random(n);
                        random_pixels += n;
                        remaining -= n;
                        wait_drained();
                    end
                    else
                        new_w = width_reg;
                end
                program_size(new_w, new_h, $urandom_range(0, 5) == 0);
            end
            n = pixels_to_frame_end();
            if ($urandom_range(0, 2) != 0 || n > remaining)
            begin
                n = $urandom_range(1, 150);
                if (n > remaining)
                    n = remaining;
            end
            queue_random(n);
            random_pixels += n;
            wait_drained();
        end

        $display("covered %0d pixels, %0d checked items and %0d register writes,",
                 pixels_accepted, results_checked, reg_writes);
        $display("frames from 3x3 up to 64 wide and 30 tall, clamped sizes, mid-frame resizing");
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
